[rtl/bof_pkg.sv]
// Package: shared types and constants of the bezier outline flattener
package bof_pkg;
  localparam int DEF_MAX_DEPTH = 6;
  localparam int MAX_POINTS = 64;

  typedef enum logic [1:0] {
    CMD_MOVE  = 2'd0,
    CMD_LINE  = 2'd1,
    CMD_QUAD  = 2'd2,
    CMD_CUBIC = 2'd3
  } cmd_t;

  localparam logic CFG_EM_SCALE  = 1'b0;
  localparam logic CFG_TOLERANCE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCALE,
    ST_POP,
    ST_TEST,
    ST_DECIDE,
    ST_EMIT
  } state_t;

  // command from controller to datapath
  typedef struct packed {
    logic load;
    logic scale_step;
    logic pop;
    logic test;
    logic split;
    logic emit_seg;
    logic emit_piece;
  } dp_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic scale_done;
    logic curve;
    logic flat;
    logic stack_empty;
    logic budget_end;
  } dp_stat_t;
endpackage

[rtl/bof_datapath.sv]
// Datapath: scaling, subdivision stack, flatness test and split of the flattener
module bof_datapath import bof_pkg::*; #(
  parameter int MAX_DEPTH = DEF_MAX_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_write,
  input  logic [0:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic [1:0]         in_command,
  input  logic signed [15:0] in_end_x,
  input  logic signed [15:0] in_end_y,
  input  logic signed [15:0] in_ctrl_a_x,
  input  logic signed [15:0] in_ctrl_a_y,
  input  logic signed [15:0] in_ctrl_b_x,
  input  logic signed [15:0] in_ctrl_b_y,
  input  dp_cmd_t            cmd,
  output dp_stat_t           stat,
  output logic signed [31:0] pt_x,
  output logic signed [31:0] pt_y,
  output logic               pt_start
);
  localparam int PIECES = MAX_DEPTH + 1;
  localparam int SPW = $clog2(PIECES + 1);
  localparam int LW = $clog2(MAX_DEPTH + 1);

  logic [31:0] em_scale_r;
  logic [30:0] tol_r;
  logic [1:0]  cmd_r;
  logic signed [15:0] raw_r [6];
  logic signed [31:0] sc_r [6];
  logic [2:0]  sidx_r;
  logic signed [31:0] cur_x_r, cur_y_r;
  logic signed [31:0] px_r [4];
  logic signed [31:0] py_r [4];
  logic [LW-1:0] lvl_r;
  logic [SPW-1:0] sp_r;
  logic [255:0] stk_r [PIECES];
  logic [LW-1:0] lvs_r [PIECES];
  logic [63:0] e_a_r, e_b_r, tol2_r;
  logic signed [31:0] pt_x_r, pt_y_r;
  logic pt_start_r;
  logic [6:0] cnt_r;

  // scaling: one multiply per cycle
  logic signed [15:0] sraw;
  logic signed [48:0] prod;
  always_comb begin
    sraw = raw_r[sidx_r];
    prod = $signed({{33{sraw[15]}}, sraw}) * $signed({17'd0, em_scale_r});
  end

  // flatness terms, sign-extended to 36 bits
  function automatic logic signed [35:0] ext(input logic signed [31:0] v);
    return {{4{v[31]}}, v};
  endfunction
  function automatic logic [63:0] sq(input logic signed [35:0] h);
    logic [35:0] m;
    logic [31:0] c;
    m = h[35] ? 36'(-h) : h;
    c = (m >= 36'h080000000) ? 32'h80000000 : m[31:0];
    return 64'(c) * 64'(c);
  endfunction

  logic signed [35:0] dqx, dqy, h0x, h0y, h1x, h1y;
  always_comb begin
    dqx = (ext(px_r[0]) - 2 * ext(px_r[1]) + ext(px_r[2])) >>> 2;
    dqy = (ext(py_r[0]) - 2 * ext(py_r[1]) + ext(py_r[2])) >>> 2;
    h0x = (3 * ext(px_r[1]) - 2 * ext(px_r[0]) - ext(px_r[3])) >>> 1;
    h0y = (3 * ext(py_r[1]) - 2 * ext(py_r[0]) - ext(py_r[3])) >>> 1;
    h1x = (3 * ext(px_r[2]) - ext(px_r[0]) - 2 * ext(px_r[3])) >>> 1;
    h1y = (3 * ext(py_r[2]) - ext(py_r[0]) - 2 * ext(py_r[3])) >>> 1;
  end

  // split
  function automatic logic signed [31:0] avg(input logic signed [31:0] a,
                                             input logic signed [31:0] b);
    logic signed [32:0] s;
    s = {a[31], a} + {b[31], b};
    return s[32:1];
  endfunction
  logic signed [31:0] ax [4], ay [4], bx [4], by [4];
  logic signed [31:0] qx, qy, rx, ry, sx, sy, qrx, qry, rsx, rsy;
  logic signed [33:0] t;
  always_comb begin
    qx = avg(px_r[0], px_r[1]); qy = avg(py_r[0], py_r[1]);
    rx = avg(px_r[1], px_r[2]); ry = avg(py_r[1], py_r[2]);
    sx = avg(px_r[2], px_r[3]); sy = avg(py_r[2], py_r[3]);
    qrx = avg(qx, rx); qry = avg(qy, ry);
    rsx = avg(rx, sx); rsy = avg(ry, sy);
    t = 34'(0);
    if (cmd_r == CMD_CUBIC) begin
      ax[0] = px_r[0]; ay[0] = py_r[0]; ax[1] = qx; ay[1] = qy;
      ax[2] = qrx; ay[2] = qry; ax[3] = avg(qrx, rsx); ay[3] = avg(qry, rsy);
      bx[0] = ax[3]; by[0] = ay[3]; bx[1] = rsx; by[1] = rsy;
      bx[2] = sx; by[2] = sy; bx[3] = px_r[3]; by[3] = py_r[3];
    end else begin
      // quadratic midpoint floor((p0 + 2c + p1) / 4)
      ax[0] = px_r[0]; ay[0] = py_r[0]; ax[1] = qx; ay[1] = qy;
      t = {{2{px_r[0][31]}}, px_r[0]} + {px_r[1][31], px_r[1], 1'b0}
        + {{2{px_r[2][31]}}, px_r[2]};
      ax[2] = t[33:2]; ax[3] = t[33:2];
      t = {{2{py_r[0][31]}}, py_r[0]} + {py_r[1][31], py_r[1], 1'b0}
        + {{2{py_r[2][31]}}, py_r[2]};
      ay[2] = t[33:2]; ay[3] = t[33:2];
      bx[0] = ax[2]; by[0] = ay[2]; bx[1] = rx; by[1] = ry;
      bx[2] = px_r[2]; by[2] = py_r[2]; bx[3] = px_r[2]; by[3] = py_r[2];
    end
  end

  logic [SPW-1:0] sp_m1;
  logic [30:0] tol_eff;
  logic over_budget;
  assign sp_m1 = sp_r - SPW'(1);
  assign tol_eff = (tol_r == 31'd0) ? 31'd1 : tol_r;
  assign over_budget = (8'(cnt_r) + 8'(sp_r) + 8'd2) > 8'(MAX_POINTS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      em_scale_r <= 32'd2097152;
      tol_r <= 31'd655;
      cur_x_r <= '0;
      cur_y_r <= '0;
      sp_r <= '0;
      sidx_r <= '0;
      cnt_r <= '0;
    end else begin
      if (cfg_write) begin
        if (cfg_index == CFG_EM_SCALE) em_scale_r <= cfg_data;
        else tol_r <= cfg_data[30:0];
      end
      if (cmd.load) begin
        cmd_r <= in_command;
        raw_r[0] <= in_end_x;    raw_r[1] <= in_end_y;
        raw_r[2] <= in_ctrl_a_x; raw_r[3] <= in_ctrl_a_y;
        raw_r[4] <= in_ctrl_b_x; raw_r[5] <= in_ctrl_b_y;
        sidx_r <= '0;
        tol2_r <= 64'(tol_eff) * 64'(tol_eff);
      end
      if (cmd.scale_step) begin
        sc_r[sidx_r] <= prod[47:16];
        sidx_r <= sidx_r + 3'd1;
      end
      if (cmd.emit_seg) begin
        pt_x_r <= sc_r[0]; pt_y_r <= sc_r[1];
        pt_start_r <= (cmd_r == CMD_MOVE);
        cur_x_r <= sc_r[0]; cur_y_r <= sc_r[1];
        cnt_r <= '0;
        if (cmd_r[1]) begin
          stk_r[0] <= {cur_x_r, cur_y_r, sc_r[2], sc_r[3],
                       (cmd_r == CMD_CUBIC) ? sc_r[4] : sc_r[0],
                       (cmd_r == CMD_CUBIC) ? sc_r[5] : sc_r[1], sc_r[0], sc_r[1]};
          lvs_r[0] <= '0;
          sp_r <= SPW'(1);
        end
      end
      if (cmd.pop) begin
        {px_r[0], py_r[0], px_r[1], py_r[1], px_r[2], py_r[2], px_r[3], py_r[3]}
          <= stk_r[sp_m1];
        lvl_r <= lvs_r[sp_m1];
        sp_r <= sp_m1;
      end
      if (cmd.test) begin
        if (cmd_r == CMD_CUBIC) begin
          e_a_r <= sq(h0x) + sq(h0y);
          e_b_r <= sq(h1x) + sq(h1y);
        end else begin
          e_a_r <= sq(dqx) + sq(dqy);
          e_b_r <= '0;
        end
      end
      if (cmd.split) begin
        stk_r[sp_r[SPW-1:0]] <= {bx[0], by[0], bx[1], by[1], bx[2], by[2], bx[3], by[3]};
        stk_r[sp_r + SPW'(1)] <= {ax[0], ay[0], ax[1], ay[1], ax[2], ay[2], ax[3], ay[3]};
        lvs_r[sp_r] <= lvl_r + LW'(1);
        lvs_r[sp_r + SPW'(1)] <= lvl_r + LW'(1);
        sp_r <= sp_r + SPW'(2);
      end
      if (cmd.emit_piece) begin
        pt_x_r <= px_r[3]; pt_y_r <= py_r[3];
        pt_start_r <= 1'b0;
        cnt_r <= cnt_r + 7'd1;
      end
    end
  end

  assign stat.scale_done = (sidx_r == 3'd5);
  assign stat.curve = cmd_r[1];
  assign stat.flat = (e_a_r <= tol2_r) && (e_b_r <= tol2_r)
                   || (32'(lvl_r) >= 32'(MAX_DEPTH)) || over_budget;
  assign stat.stack_empty = (sp_r == '0);
  assign stat.budget_end = (cnt_r == 7'(MAX_POINTS - 1));
  assign pt_x = pt_x_r;
  assign pt_y = pt_y_r;
  assign pt_start = pt_start_r;
endmodule

[rtl/bof_control.sv]
// Controller: sequences scaling, stack pops, tests and point output
module bof_control import bof_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  output logic     out_last,
  input  logic     out_stall,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);
  state_t state_r, state_nxt;
  logic ov_r, ov_nxt, last_r, last_nxt;
  logic can_emit;
  logic piece_done;
  assign can_emit = !ov_r || !out_stall;
  assign piece_done = stat.stack_empty || stat.budget_end;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = ST_SCALE;
      ST_SCALE:  if (stat.scale_done) state_nxt = ST_EMIT;
      ST_EMIT:   if (can_emit) state_nxt = stat.curve ? ST_POP : ST_IDLE;
      ST_POP:    state_nxt = ST_TEST;
      ST_TEST:   state_nxt = ST_DECIDE;
      ST_DECIDE: begin
        if (!stat.flat) state_nxt = ST_POP;
        else if (can_emit) state_nxt = piece_done ? ST_IDLE : ST_POP;
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_stall = (state_r != ST_IDLE);
    ov_nxt = ov_r && out_stall;
    last_nxt = last_r;
    case (state_r)
      ST_IDLE:  cmd.load = in_valid;
      ST_SCALE: cmd.scale_step = 1'b1;
      ST_EMIT: begin
        if (can_emit) begin
          cmd.emit_seg = 1'b1;
          if (!stat.curve) begin
            ov_nxt = 1'b1;
            last_nxt = 1'b1;
          end
        end
      end
      ST_POP:  cmd.pop = 1'b1;
      ST_TEST: cmd.test = 1'b1;
      ST_DECIDE: begin
        if (!stat.flat) cmd.split = 1'b1;
        else if (can_emit) begin
          cmd.emit_piece = 1'b1;
          ov_nxt = 1'b1;
          last_nxt = piece_done;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ov_r <= 1'b0;
      last_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r <= ov_nxt;
      last_r <= last_nxt;
    end
  end

  assign out_valid = ov_r;
  assign out_last = last_r;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid) else $error("request dropped");
  a_noacc: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_IDLE |-> in_stall) else $error("accept while busy");
  a_emit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_piece |-> can_emit && !cmd.split) else $error("emit over pending");
endmodule

[rtl/bezier_outline_flattener.sv]
// Top level of the bezier outline flattener
// Usage: write em_scale (index 0) and tolerance (index 1) on the cfg port
// while idle. Send one segment per request on the in_ channel; each point
// leaves on the out_ channel as one request, contour_start on a move,
// last_point on the final point of the segment.
// A move or line is scaled by six serial multiplies and its point is
// registered in the emit state; the next request is taken once the
// controller is back in idle.
// A curve is scaled the same way, then works each popped piece of the
// subdivision stack through pop, flatness test and decide; the stack loop
// sets the rate, up to 2^(MAX_DEPTH+1)-1 pieces per curve.
// One segment is worked at a time; in_stall is high while busy.
// The output register holds a point while out_stall is high; the
// controller then waits and nothing is lost.
// Reset: synchronous, active low; restores register defaults and clears
// the current point to zero.
module bezier_outline_flattener import bof_pkg::*; #(
  parameter int MAX_DEPTH = DEF_MAX_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_write,
  input  logic [0:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_command,
  input  logic signed [15:0] in_end_x,
  input  logic signed [15:0] in_end_y,
  input  logic signed [15:0] in_ctrl_a_x,
  input  logic signed [15:0] in_ctrl_a_y,
  input  logic signed [15:0] in_ctrl_b_x,
  input  logic signed [15:0] in_ctrl_b_y,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_point_x,
  output logic signed [31:0] out_point_y,
  output logic               out_contour_start,
  output logic               out_last_point
);
  dp_cmd_t  cmd;
  dp_stat_t stat;

  bof_control u_ctl (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid,
    .out_last(out_last_point), .out_stall, .stat, .cmd
  );

  bof_datapath #(.MAX_DEPTH(MAX_DEPTH)) u_dp (
    .clk, .rst_n, .cfg_write, .cfg_index, .cfg_data,
    .in_command, .in_end_x, .in_end_y, .in_ctrl_a_x, .in_ctrl_a_y,
    .in_ctrl_b_x, .in_ctrl_b_y, .cmd, .stat,
    .pt_x(out_point_x), .pt_y(out_point_y), .pt_start(out_contour_start)
  );
endmodule
